// ===== rtl/core/smeu_pkg.sv =====
`timescale 1ns / 1ps

package smeu_pkg;

  // Machine sizes
  localparam int DATA_W         = 32;
  localparam int STACK_DEPTH    = 128;
  localparam int VARIABLE_COUNT = 26;
  localparam int CODE_DEPTH     = 1024;

  // Derived widths
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int VAR_IDX_W   = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
  localparam int PC_W        = $clog2(CODE_DEPTH);
  localparam int PLEN_W      = PC_W + 1;
  localparam int ERR_W       = 3;
  localparam int KIND_W      = 2;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  // Config register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_PROGRAM_LENGTH = '0;

  // Instruction opcodes
  typedef enum logic [3:0] {
    OP_POP      = 4'd0,
    OP_PUSH_VAR = 4'd1,
    OP_PUSH_LIT = 4'd2,
    OP_CALC     = 4'd3,
    OP_JUMP     = 4'd4,
    OP_JUMP_IFZ = 4'd5,
    OP_GET      = 4'd6,
    OP_PUT_INT  = 4'd7,
    OP_PUT_STR  = 4'd8
  } op_t;

  // Calc codes
  typedef enum logic [3:0] {
    CALC_ADD = 4'd0,
    CALC_SUB = 4'd1,
    CALC_NEG = 4'd2,
    CALC_MUL = 4'd3,
    CALC_DIV = 4'd4,
    CALC_EQ  = 4'd5,
    CALC_GT  = 4'd6,
    CALC_LT  = 4'd7,
    CALC_LE  = 4'd8,
    CALC_NE  = 4'd9
  } calc_code_t;

  localparam logic [DATA_W-1:0] CALC_LAST = DATA_W'(CALC_NE);

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_VAR   = 3'd4;

  // Output kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STR  = 2'd2;

  // Sequencer to arithmetic unit
  typedef struct packed {
    logic              start;
    calc_code_t        code;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  // Arithmetic unit to sequencer
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

// ===== rtl/core/smeu_ram.sv =====
`timescale 1ns / 1ps

module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/smeu_alu.sv =====
`timescale 1ns / 1ps

module smeu_alu
  import smeu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  typedef enum logic [2:0] {
    AS_IDLE = 3'b001,
    AS_DIV  = 3'b010,
    AS_FIX  = 3'b100
  } alu_state_t;

  alu_state_t            state;
  logic                  done;
  logic [DATA_W-1:0]     result;
  logic [DATA_W-1:0]     quo;
  logic [DATA_W-1:0]     rem;
  logic [DATA_W-1:0]     divisor;
  logic                  neg;
  logic [DIV_CNT_W-1:0]  cnt;

  logic [DATA_W-1:0] simple;
  logic [DATA_W-1:0] mul_lo;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign mul_lo = req.a * req.b;
  assign mag_a  = req.a[DATA_W-1] ? (DATA_W'(0) - req.a) : req.a;
  assign mag_b  = req.b[DATA_W-1] ? (DATA_W'(0) - req.b) : req.b;

  // Combinational operations, registered when started
  always_comb begin
    case (req.code)
      CALC_ADD: simple = req.a + req.b;
      CALC_SUB: simple = req.a - req.b;
      CALC_NEG: simple = DATA_W'(0) - req.b;
      CALC_MUL: simple = mul_lo;
      CALC_EQ:  simple = DATA_W'(req.a == req.b);
      CALC_GT:  simple = DATA_W'($signed(req.b) < $signed(req.a));
      CALC_LT:  simple = DATA_W'($signed(req.a) < $signed(req.b));
      CALC_LE:  simple = DATA_W'(!($signed(req.b) < $signed(req.a)));
      CALC_NE:  simple = DATA_W'(req.a != req.b);
      default:  simple = '0;
    endcase
  end

  // Restoring divide step, one quotient bit per cycle
  assign rem_sh = {rem, quo[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        AS_IDLE: begin
          if (req.start) begin
            if (req.code == CALC_DIV) begin
              quo     <= mag_a;
              rem     <= '0;
              divisor <= mag_b;
              neg     <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
              cnt     <= DIV_CNT_W'(DATA_W - 1);
              state   <= AS_DIV;
            end else begin
              result <= simple;
              done   <= 1'b1;
            end
          end
        end
        AS_DIV: begin
          if (!diff[DATA_W]) begin
            rem <= diff[DATA_W-1:0];
            quo <= {quo[DATA_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[DATA_W-1:0];
            quo <= {quo[DATA_W-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= AS_FIX;
          end else begin
            cnt <= cnt - DIV_CNT_W'(1);
          end
        end
        AS_FIX: begin
          // Sign of quotient; -2^31 / -1 wraps naturally
          result <= neg ? (DATA_W'(0) - quo) : quo;
          done   <= 1'b1;
          state  <= AS_IDLE;
        end
        default: begin
          state <= AS_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

// ===== rtl/core/stack_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// Sequence: each instruction is taken in idle and decoded; pop and jump-if-false then read
// the top of stack, negate reads it and runs the arithmetic unit, the other calc codes read
// two entries and run the unit, and divide by zero ends after the second read. Divide forms
// its 32 quotient bits, one per cycle in the shared arithmetic unit, then fixes the sign.
// Throughput: one instruction at a time; the next is taken once the result is registered.
// Reset (rst, synchronous, active high): clears pc, halt flag, stack count, variables and
// program_length; the operand stack storage is not cleared.

module stack_machine_execute_unit
  import smeu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Instruction stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [71:0]           s_tdata,   // op[3:0], operand[35:4], input_value[67:36]
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // next_pc[9:0], out_value[41:10], halted[42],
                                           // error_code[45:43]
  output logic [KIND_W-1:0]     m_tuser,   // out_kind[1:0]
  // Config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_RD_B   = 6'b000100,
    ST_RD_A   = 6'b001000,
    ST_EXEC   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t                 state;
  logic [PLEN_W-1:0]      program_length;
  logic [PC_W-1:0]        pc;
  logic                   halt_flag;
  logic [STACK_CNT_W-1:0] stack_count;
  logic [DATA_W-1:0]      variables [VARIABLE_COUNT];

  // Current instruction and its outcome
  op_t                    op_q;
  logic [DATA_W-1:0]      arg_q;
  logic [DATA_W-1:0]      inval_q;
  logic [DATA_W-1:0]      b_q;
  logic                   skip_q;
  logic [ERR_W-1:0]       err_q;
  logic [KIND_W-1:0]      kind_q;
  logic [DATA_W-1:0]      value_q;
  logic [PC_W-1:0]        next_q;

  // Result register
  logic [PC_W-1:0]        out_next_pc;
  logic [KIND_W-1:0]      out_kind;
  logic [DATA_W-1:0]      out_value;
  logic                   out_halted;
  logic [ERR_W-1:0]       out_err;

  // Stack memory ports
  logic                   ram_we;
  logic [STACK_AW-1:0]    ram_waddr;
  logic [DATA_W-1:0]      ram_wdata;
  logic [STACK_AW-1:0]    ram_raddr;
  logic [DATA_W-1:0]      ram_rdata;

  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  logic                   cfg_write;
  logic                   var_ok;
  logic                   calc_ok;
  logic                   is_neg;
  logic                   pass_halted;
  logic                   out_free;
  logic [VAR_IDX_W-1:0]   var_idx;
  logic [STACK_CNT_W-1:0] cnt_m1;
  logic [STACK_CNT_W-1:0] cnt_m2;
  logic [PC_W-1:0]        pc_inc;
  logic [PC_W-1:0]        jump_pc;
  calc_code_t             calc_code;

  // Config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[CFG_ADDR_W-1:2] == REG_PROGRAM_LENGTH);
  assign prdata    = (paddr[CFG_ADDR_W-1:2] == REG_PROGRAM_LENGTH) ?
                     32'(program_length) : 32'd0;

  // Decode helpers
  assign var_ok      = arg_q < DATA_W'(VARIABLE_COUNT);
  assign calc_ok     = arg_q <= CALC_LAST;
  assign calc_code   = calc_code_t'(arg_q[3:0]);
  assign is_neg      = calc_code == CALC_NEG;
  assign var_idx     = arg_q[VAR_IDX_W-1:0];
  assign cnt_m1      = stack_count - STACK_CNT_W'(1);
  assign cnt_m2      = stack_count - STACK_CNT_W'(2);
  assign pc_inc      = pc + PC_W'(1);
  assign jump_pc     = arg_q[PC_W-1:0] + PC_W'(1);
  assign pass_halted = halt_flag || ({1'b0, pc} >= program_length);
  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = state == ST_IDLE;

  // Stack reads: top in decode, second in RD_B
  assign ram_raddr = (state == ST_RD_B) ? cnt_m2[STACK_AW-1:0] : cnt_m1[STACK_AW-1:0];

  // Stack writes: pushes in decode, calc write-back when the unit finishes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = stack_count[STACK_AW-1:0];
    ram_wdata = (op_q == OP_PUSH_VAR) ? variables[var_idx] : arg_q;
    if (state == ST_DECODE && !pass_halted && stack_count != STACK_CNT_W'(STACK_DEPTH) &&
        ((op_q == OP_PUSH_VAR && var_ok) || op_q == OP_PUSH_LIT)) begin
      ram_we = 1'b1;
    end else if (state == ST_EXEC && alu_rsp.done) begin
      ram_we    = 1'b1;
      ram_waddr = is_neg ? cnt_m1[STACK_AW-1:0] : cnt_m2[STACK_AW-1:0];
      ram_wdata = alu_rsp.result;
    end
  end

  // Arithmetic unit requests
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.code  = calc_code;
    alu_req.a     = ram_rdata;
    alu_req.b     = b_q;
    if (state == ST_RD_B) begin
      alu_req.start = (op_q == OP_CALC) && is_neg;
      alu_req.code  = CALC_NEG;
      alu_req.b     = ram_rdata;
    end else if (state == ST_RD_A) begin
      alu_req.start = !(calc_code == CALC_DIV && b_q == '0);
    end
  end

  smeu_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  smeu_alu u_alu (
    .clk(clk),
    .rst(rst),
    .req(alu_req),
    .rsp(alu_rsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      program_length <= '0;
      pc             <= '0;
      halt_flag      <= 1'b0;
      stack_count    <= '0;
      m_tvalid       <= 1'b0;
      for (int i = 0; i < VARIABLE_COUNT; i++) begin
        variables[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        program_length <= pwdata[PLEN_W-1:0];
      end
      // Finish reloads the result register itself
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_q    <= op_t'(s_tdata[3:0]);
            arg_q   <= s_tdata[35:4];
            inval_q <= s_tdata[67:36];
            state   <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          skip_q  <= pass_halted;
          err_q   <= ERR_NONE;
          kind_q  <= KIND_NONE;
          value_q <= '0;
          next_q  <= pc_inc;
          state   <= ST_FINISH;
          if (!pass_halted) begin
            case (op_q)
              OP_POP: begin
                if (!var_ok) begin
                  err_q <= ERR_BAD_VAR;
                end else if (stack_count == '0) begin
                  err_q <= ERR_UNDERFLOW;
                end else begin
                  state <= ST_RD_B;
                end
              end
              OP_PUSH_VAR, OP_PUSH_LIT: begin
                if (op_q == OP_PUSH_VAR && !var_ok) begin
                  err_q <= ERR_BAD_VAR;
                end else if (stack_count == STACK_CNT_W'(STACK_DEPTH)) begin
                  err_q <= ERR_OVERFLOW;
                end else begin
                  stack_count <= stack_count + STACK_CNT_W'(1);
                end
              end
              OP_CALC: begin
                if (calc_ok) begin
                  if (is_neg ? (stack_count == '0) : (stack_count < STACK_CNT_W'(2))) begin
                    err_q <= ERR_UNDERFLOW;
                  end else begin
                    state <= ST_RD_B;
                  end
                end
              end
              OP_JUMP: begin
                next_q <= jump_pc;
              end
              OP_JUMP_IFZ: begin
                if (stack_count == '0) begin
                  err_q <= ERR_UNDERFLOW;
                end else begin
                  state <= ST_RD_B;
                end
              end
              OP_GET: begin
                if (!var_ok) begin
                  err_q <= ERR_BAD_VAR;
                end else begin
                  variables[var_idx] <= inval_q;
                end
              end
              OP_PUT_INT: begin
                kind_q  <= KIND_INT;
                value_q <= arg_q;
              end
              OP_PUT_STR: begin
                kind_q  <= KIND_STR;
                value_q <= arg_q;
              end
              default: begin
              end
            endcase
          end
        end

        // Top of stack is on the read port
        ST_RD_B: begin
          b_q <= ram_rdata;
          case (op_q)
            OP_POP: begin
              variables[var_idx] <= ram_rdata;
              stack_count        <= cnt_m1;
              state              <= ST_FINISH;
            end
            OP_JUMP_IFZ: begin
              stack_count <= cnt_m1;
              if (ram_rdata == '0) begin
                next_q <= jump_pc;
              end
              state <= ST_FINISH;
            end
            default: begin
              state <= is_neg ? ST_EXEC : ST_RD_A;
            end
          endcase
        end

        // Second entry is on the read port
        ST_RD_A: begin
          if (calc_code == CALC_DIV && b_q == '0) begin
            err_q <= ERR_DIV_ZERO;
            state <= ST_FINISH;
          end else begin
            state <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          if (alu_rsp.done) begin
            if (!is_neg) begin
              stack_count <= cnt_m1;
            end
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_err  <= skip_q ? ERR_NONE : err_q;
            if (skip_q || err_q != ERR_NONE) begin
              halt_flag   <= 1'b1;
              out_next_pc <= pc;
              out_kind    <= KIND_NONE;
              out_value   <= '0;
              out_halted  <= 1'b1;
            end else begin
              pc          <= next_q;
              halt_flag   <= {1'b0, next_q} >= program_length;
              out_next_pc <= next_q;
              out_kind    <= kind_q;
              out_value   <= value_q;
              out_halted  <= {1'b0, next_q} >= program_length;
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {2'b00, out_err, out_halted, out_value, out_next_pc};
  assign m_tuser = out_kind;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= STACK_CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_err != ERR_NONE |-> out_halted && halt_flag)
    else $error("error result without halt");

  a_done_in_exec: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == ST_EXEC)
    else $error("arithmetic result outside execute");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish");

endmodule
